// File: design/jtl_pkg.sv
`default_nettype none

package jtl_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int S_TDATA_W         = 8;
    localparam int M_TDATA_W         = 48;
    localparam int M_TUSER_W         = 7;
    localparam int EVENT_SLOTS       = 3;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_STRING   = 3'd1,
        MODE_ESCAPE   = 3'd2,
        MODE_INTEGER  = 3'd3,
        MODE_FRACTION = 3'd4,
        MODE_KEYWORD  = 3'd5,
        MODE_ERROR    = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        EV_START = 3'd0,
        EV_VALUE = 3'd1,
        EV_END   = 3'd2,
        EV_WHOLE = 3'd3,
        EV_ERROR = 3'd4
    } event_code_t;

    typedef enum logic [3:0] {
        TOK_LBRACE   = 4'd0,
        TOK_RBRACE   = 4'd1,
        TOK_LBRACKET = 4'd2,
        TOK_RBRACKET = 4'd3,
        TOK_COLON    = 4'd4,
        TOK_COMMA    = 4'd5,
        TOK_STRING   = 4'd6,
        TOK_NUMBER   = 4'd7,
        TOK_TRUE     = 4'd8,
        TOK_FALSE    = 4'd9,
        TOK_NULL     = 4'd10,
        TOK_EOF      = 4'd11
    } token_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_CHAR   = 2'd1,
        ERR_UNTERM = 2'd2,
        ERR_WORD   = 2'd3
    } error_code_t;

    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_LOWER_N  = 8'h6E;
    localparam logic [7:0] CH_LOWER_T  = 8'h74;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;

    // true, false, null
    localparam logic [7:0] WORD_TEXT [3][8] = '{
        '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] WORD_LEN [3] = '{3'd4, 3'd5, 3'd4};

    localparam logic [2:0] KLEN_MAX = 3'd7;

    typedef struct packed {
        logic [2:0] cand;
        logic [2:0] klen;
    } kw_state_t;

    typedef struct packed {
        mode_t     mode;
        kw_state_t kw;
    } lex_ctl_t;

    typedef struct packed {
        token_kind_t kind;
        event_code_t code;
        logic [7:0]  value;
        logic [15:0] line;
        logic [15:0] column;
        error_code_t err;
    } event_t;

    typedef struct packed {
        logic [1:0]   count;
        event_t [2:0] slot;
    } event_set_t;

    typedef struct packed {
        logic        hit;
        token_kind_t kind;
    } kw_match_t;

    typedef struct packed {
        logic [1:0] count;
        event_t     e0;
        event_t     e1;
        mode_t      mode;
        logic       set_token;
        logic       kw_init;
    } idle_res_t;

    function automatic event_t mk_event(token_kind_t kind, event_code_t code,
                                        logic [7:0] value, logic [15:0] line,
                                        logic [15:0] column, error_code_t err);
        event_t e;
        e.kind   = kind;
        e.code   = code;
        e.value  = value;
        e.line   = line;
        e.column = column;
        e.err    = err;
        return e;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic is_punct(logic [7:0] b);
        return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LBRACKET) ||
               (b == CH_RBRACKET) || (b == CH_COLON) || (b == CH_COMMA);
    endfunction

    function automatic token_kind_t punct_kind(logic [7:0] b);
        token_kind_t k;
        case (b)
            CH_RBRACE: begin
                k = TOK_RBRACE;
            end
            CH_LBRACKET: begin
                k = TOK_LBRACKET;
            end
            CH_RBRACKET: begin
                k = TOK_RBRACKET;
            end
            CH_COLON: begin
                k = TOK_COLON;
            end
            CH_COMMA: begin
                k = TOK_COMMA;
            end
            default: begin
                k = TOK_LBRACE;
            end
        endcase
        return k;
    endfunction

    function automatic kw_state_t keyword_feed(kw_state_t s, logic [7:0] b);
        kw_state_t r;
        r = s;
        for (int k = 0; k < 3; k++) begin
            if (!((s.klen < WORD_LEN[k]) && (WORD_TEXT[k][s.klen] == b))) begin
                r.cand[k] = 1'b0;
            end
        end
        if (s.klen != KLEN_MAX) begin
            r.klen = s.klen + 3'd1;
        end
        return r;
    endfunction

    function automatic kw_match_t keyword_match(kw_state_t s);
        kw_match_t r;
        r.hit  = 1'b0;
        r.kind = TOK_TRUE;
        if (s.cand[0] && (s.klen == WORD_LEN[0])) begin
            r.hit  = 1'b1;
            r.kind = TOK_TRUE;
        end else if (s.cand[1] && (s.klen == WORD_LEN[1])) begin
            r.hit  = 1'b1;
            r.kind = TOK_FALSE;
        end else if (s.cand[2] && (s.klen == WORD_LEN[2])) begin
            r.hit  = 1'b1;
            r.kind = TOK_NULL;
        end
        return r;
    endfunction

    // byte seen with no token open
    function automatic idle_res_t idle_byte(logic [7:0] b, logic [15:0] ln,
                                            logic [15:0] cl);
        idle_res_t r;
        r.count     = 2'd0;
        r.e0        = mk_event(TOK_LBRACE, EV_START, 8'h00, ln, cl, ERR_NONE);
        r.e1        = r.e0;
        r.mode      = MODE_IDLE;
        r.set_token = 1'b0;
        r.kw_init   = 1'b0;
        if (is_space(b)) begin
            r.count = 2'd0;
        end else if (is_punct(b)) begin
            r.count = 2'd1;
            r.e0    = mk_event(punct_kind(b), EV_WHOLE, b, ln, cl, ERR_NONE);
        end else begin
            r.set_token = 1'b1;
            if (b == CH_QUOTE) begin
                r.count = 2'd1;
                r.e0    = mk_event(TOK_STRING, EV_START, b, ln, cl, ERR_NONE);
                r.mode  = MODE_STRING;
            end else if (is_digit(b) || (b == CH_MINUS)) begin
                r.count = 2'd2;
                r.e0    = mk_event(TOK_NUMBER, EV_START, b, ln, cl, ERR_NONE);
                r.e1    = mk_event(TOK_NUMBER, EV_VALUE, b, ln, cl, ERR_NONE);
                r.mode  = MODE_INTEGER;
            end else if (is_alpha(b)) begin
                r.kw_init = 1'b1;
                r.mode    = MODE_KEYWORD;
            end else begin
                r.count = 2'd1;
                r.e0    = mk_event(TOK_LBRACE, EV_ERROR, b, ln, cl, ERR_CHAR);
                r.mode  = MODE_ERROR;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/jtl_step.sv
`default_nettype none

module jtl_step #(
    parameter int POSITION_BITS = jtl_pkg::POSITION_BITS_DEF
) (
    input  wire jtl_pkg::lex_ctl_t    ctl,
    input  wire [POSITION_BITS-1:0]   line_cnt,
    input  wire [POSITION_BITS-1:0]   col_cnt,
    input  wire [POSITION_BITS-1:0]   tok_line,
    input  wire [POSITION_BITS-1:0]   tok_col,
    input  wire [7:0]                 text_byte,
    input  wire                       end_of_text,
    output jtl_pkg::lex_ctl_t         ctl_next,
    output logic [POSITION_BITS-1:0]  line_next,
    output logic [POSITION_BITS-1:0]  col_next,
    output logic [POSITION_BITS-1:0]  tok_line_next,
    output logic [POSITION_BITS-1:0]  tok_col_next,
    output jtl_pkg::event_set_t       events
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

    logic [15:0]           ln16;
    logic [15:0]           cl16;
    logic [15:0]           tl16;
    logic [15:0]           tc16;
    jtl_pkg::idle_res_t    idl;
    jtl_pkg::kw_match_t    kwm;
    jtl_pkg::kw_state_t    kw_fed;
    jtl_pkg::kw_state_t    kw_first;
    jtl_pkg::kw_state_t    kw_fresh;
    logic                  pre_v;
    jtl_pkg::event_t       pre_e;
    logic                  use_idle;
    logic                  eof_v;
    jtl_pkg::event_t       eof_e;
    logic [3:0]            cv;
    jtl_pkg::event_t [3:0] ce;
    logic [2:0]            n;
    logic [7:0]            esc_val;

    assign ln16 = 16'(line_cnt);
    assign cl16 = 16'(col_cnt);
    assign tl16 = 16'(tok_line);
    assign tc16 = 16'(tok_col);

    assign kw_fresh.cand = 3'b111;
    assign kw_fresh.klen = 3'd0;

    assign idl      = jtl_pkg::idle_byte(text_byte, ln16, cl16);
    assign kwm      = jtl_pkg::keyword_match(ctl.kw);
    assign kw_fed   = jtl_pkg::keyword_feed(ctl.kw, text_byte);
    assign kw_first = jtl_pkg::keyword_feed(kw_fresh, text_byte);
    assign eof_e    = jtl_pkg::mk_event(jtl_pkg::TOK_EOF, jtl_pkg::EV_WHOLE, 8'h00,
                                        ln16, cl16, jtl_pkg::ERR_NONE);

    always_comb begin
        case (text_byte)
            jtl_pkg::CH_LOWER_N: begin
                esc_val = jtl_pkg::CH_LF;
            end
            jtl_pkg::CH_LOWER_T: begin
                esc_val = jtl_pkg::CH_TAB;
            end
            default: begin
                esc_val = text_byte;
            end
        endcase
    end

    always_comb begin
        ctl_next      = ctl;
        tok_line_next = tok_line;
        tok_col_next  = tok_col;
        pre_v         = 1'b0;
        pre_e         = eof_e;
        use_idle      = 1'b0;
        eof_v         = 1'b0;
        if (end_of_text) begin
            eof_v         = 1'b1;
            ctl_next.mode = jtl_pkg::MODE_IDLE;
            case (ctl.mode)
                jtl_pkg::MODE_STRING, jtl_pkg::MODE_ESCAPE: begin
                    pre_v = 1'b1;
                    pre_e = jtl_pkg::mk_event(jtl_pkg::TOK_LBRACE, jtl_pkg::EV_ERROR,
                                              8'h00, tl16, tc16, jtl_pkg::ERR_UNTERM);
                end
                jtl_pkg::MODE_INTEGER, jtl_pkg::MODE_FRACTION: begin
                    pre_v = 1'b1;
                    pre_e = jtl_pkg::mk_event(jtl_pkg::TOK_NUMBER, jtl_pkg::EV_END,
                                              8'h00, tl16, tc16, jtl_pkg::ERR_NONE);
                end
                jtl_pkg::MODE_KEYWORD: begin
                    pre_v = 1'b1;
                    if (kwm.hit) begin
                        pre_e = jtl_pkg::mk_event(kwm.kind, jtl_pkg::EV_WHOLE,
                                                  8'h00, tl16, tc16, jtl_pkg::ERR_NONE);
                    end else begin
                        pre_e = jtl_pkg::mk_event(jtl_pkg::TOK_LBRACE, jtl_pkg::EV_ERROR,
                                                  8'h00, tl16, tc16, jtl_pkg::ERR_WORD);
                    end
                end
                default: begin
                    pre_v = 1'b0;
                end
            endcase
        end else begin
            case (ctl.mode)
                jtl_pkg::MODE_ERROR: begin
                    pre_v = 1'b0;
                end
                jtl_pkg::MODE_STRING: begin
                    if (text_byte == jtl_pkg::CH_QUOTE) begin
                        pre_v         = 1'b1;
                        pre_e         = jtl_pkg::mk_event(jtl_pkg::TOK_STRING,
                                            jtl_pkg::EV_END, text_byte, tl16, tc16,
                                            jtl_pkg::ERR_NONE);
                        ctl_next.mode = jtl_pkg::MODE_IDLE;
                    end else if (text_byte == jtl_pkg::CH_BSLASH) begin
                        ctl_next.mode = jtl_pkg::MODE_ESCAPE;
                    end else begin
                        pre_v = 1'b1;
                        pre_e = jtl_pkg::mk_event(jtl_pkg::TOK_STRING, jtl_pkg::EV_VALUE,
                                                  text_byte, tl16, tc16, jtl_pkg::ERR_NONE);
                    end
                end
                jtl_pkg::MODE_ESCAPE: begin
                    pre_v         = 1'b1;
                    pre_e         = jtl_pkg::mk_event(jtl_pkg::TOK_STRING, jtl_pkg::EV_VALUE,
                                                      esc_val, tl16, tc16, jtl_pkg::ERR_NONE);
                    ctl_next.mode = jtl_pkg::MODE_STRING;
                end
                jtl_pkg::MODE_INTEGER, jtl_pkg::MODE_FRACTION: begin
                    pre_v = 1'b1;
                    if (jtl_pkg::is_digit(text_byte) ||
                        ((ctl.mode == jtl_pkg::MODE_INTEGER) &&
                         (text_byte == jtl_pkg::CH_DOT))) begin
                        pre_e = jtl_pkg::mk_event(jtl_pkg::TOK_NUMBER, jtl_pkg::EV_VALUE,
                                                  text_byte, tl16, tc16, jtl_pkg::ERR_NONE);
                        if (text_byte == jtl_pkg::CH_DOT) begin
                            ctl_next.mode = jtl_pkg::MODE_FRACTION;
                        end
                    end else begin
                        pre_e    = jtl_pkg::mk_event(jtl_pkg::TOK_NUMBER, jtl_pkg::EV_END,
                                                     8'h00, tl16, tc16, jtl_pkg::ERR_NONE);
                        use_idle = 1'b1;
                    end
                end
                jtl_pkg::MODE_KEYWORD: begin
                    if (jtl_pkg::is_alpha(text_byte)) begin
                        ctl_next.kw = kw_fed;
                    end else if (kwm.hit) begin
                        pre_v    = 1'b1;
                        pre_e    = jtl_pkg::mk_event(kwm.kind, jtl_pkg::EV_WHOLE,
                                                     8'h00, tl16, tc16, jtl_pkg::ERR_NONE);
                        use_idle = 1'b1;
                    end else begin
                        pre_v         = 1'b1;
                        pre_e         = jtl_pkg::mk_event(jtl_pkg::TOK_LBRACE,
                                            jtl_pkg::EV_ERROR, 8'h00, tl16, tc16,
                                            jtl_pkg::ERR_WORD);
                        ctl_next.mode = jtl_pkg::MODE_ERROR;
                    end
                end
                default: begin
                    use_idle = 1'b1;
                end
            endcase
            if (use_idle) begin
                ctl_next.mode = idl.mode;
                if (idl.set_token) begin
                    tok_line_next = line_cnt;
                    tok_col_next  = col_cnt;
                end
                if (idl.kw_init) begin
                    ctl_next.kw = kw_first;
                end
            end
        end
    end

    always_comb begin
        if (end_of_text) begin
            line_next = POS_ONE;
            col_next  = POS_ONE;
        end else if (text_byte == jtl_pkg::CH_LF) begin
            line_next = (line_cnt != POS_MAX) ? line_cnt + POS_ONE : line_cnt;
            col_next  = POS_ONE;
        end else begin
            line_next = line_cnt;
            col_next  = (col_cnt != POS_MAX) ? col_cnt + POS_ONE : col_cnt;
        end
    end

    // pack up to three events in order
    assign cv[0] = pre_v;
    assign cv[1] = use_idle && (idl.count != 2'd0);
    assign cv[2] = use_idle && (idl.count == 2'd2);
    assign cv[3] = eof_v;
    assign ce[0] = pre_e;
    assign ce[1] = idl.e0;
    assign ce[2] = idl.e1;
    assign ce[3] = eof_e;

    always_comb begin
        events.slot = {jtl_pkg::EVENT_SLOTS{eof_e}};
        n           = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (cv[i]) begin
                if (n < 3'd3) begin
                    events.slot[n[1:0]] = ce[i];
                end
                n = n + 3'd1;
            end
        end
        events.count = n[1:0];
    end

endmodule

`default_nettype wire

// File: design/jtl_evt_buf.sv
`default_nettype none

module jtl_evt_buf (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       load,
    input  wire jtl_pkg::event_set_t  events,
    output logic                      free,
    output logic                      out_valid,
    input  wire                       out_ready,
    output jtl_pkg::event_t           out_event,
    output logic                      out_last
);

    jtl_pkg::event_t [2:0] slot_reg;
    jtl_pkg::event_t [2:0] slot_next;
    logic [1:0]            left_reg;
    logic [1:0]            left_next;
    logic [1:0]            rd_reg;
    logic [1:0]            rd_next;
    logic                  pop;

    assign out_valid = (left_reg != 2'd0);
    assign out_last  = (left_reg == 2'd1);
    assign out_event = slot_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign free      = (left_reg == 2'd0) || (out_last && out_ready);

    always_comb begin
        slot_next = slot_reg;
        left_next = left_reg;
        rd_next   = rd_reg;
        if (load) begin
            slot_next = events.slot;
            left_next = events.count;
            rd_next   = 2'd0;
        end else if (pop) begin
            left_next = left_reg - 2'd1;
            rd_next   = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        if (!aresetn) begin
            left_reg <= 2'd0;
            rd_reg   <= 2'd0;
        end else begin
            left_reg <= left_next;
            rd_reg   <= rd_next;
        end
    end

endmodule

`default_nettype wire

// File: design/json_token_lexer_core.sv
// Channel | Dir | tdata                              | tuser               | tlast
// s_      | in  | [7:0] text_byte                    | -                   | end_of_text
// m_      | out | [7:0] value_byte, [23:8] line,     | [3:0] token_kind,   | last_of_run
//         |     | [39:24] column, [41:40] error_code | [6:4] event_res     |
//
// One word in per cycle while the event register is free; a word that yields several
// events holds the input until its last event is taken. A word passes the input
// register, then the event register; the lexer step between them is one pass.
// Reset (aresetn low, synchronous) clears mode and position, no clearing pass.
// Input register frees as soon as the event register takes its events.
`default_nettype none

module json_token_lexer_core #(
    parameter int POSITION_BITS = jtl_pkg::POSITION_BITS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [jtl_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] text_byte
    input  wire                            s_tlast,   // end_of_text
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [jtl_pkg::M_TDATA_W-1:0]  m_tdata,   // value_byte, line, column, error_code
    output logic [jtl_pkg::M_TUSER_W-1:0]  m_tuser,   // token_kind, event_res
    output logic                           m_tlast    // last_of_run
);

    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic [7:0]                 in_byte_reg;
    logic                       in_end_reg;
    logic                       s_fire;
    logic                       proc;
    logic                       buf_free;

    jtl_pkg::lex_ctl_t          ctl_reg;
    jtl_pkg::lex_ctl_t          ctl_next;
    logic [POSITION_BITS-1:0]   line_reg;
    logic [POSITION_BITS-1:0]   line_next;
    logic [POSITION_BITS-1:0]   col_reg;
    logic [POSITION_BITS-1:0]   col_next;
    logic [POSITION_BITS-1:0]   tok_line_reg;
    logic [POSITION_BITS-1:0]   tok_line_next;
    logic [POSITION_BITS-1:0]   tok_col_reg;
    logic [POSITION_BITS-1:0]   tok_col_next;

    jtl_pkg::event_set_t        events;
    jtl_pkg::event_t            out_event;

    assign s_fire        = s_tvalid && s_tready;
    assign proc          = in_valid_reg && buf_free;
    assign s_tready      = !in_valid_reg || proc;
    assign in_valid_next = s_fire ? 1'b1 : (proc ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata[7:0];
            in_end_reg  <= s_tlast;
        end
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            ctl_reg.mode  <= jtl_pkg::MODE_IDLE;
            ctl_reg.kw    <= {3'b111, 3'd0};
            line_reg      <= POS_ONE;
            col_reg       <= POS_ONE;
            tok_line_reg  <= POS_ONE;
            tok_col_reg   <= POS_ONE;
        end else begin
            in_valid_reg <= in_valid_next;
            if (proc) begin
                ctl_reg      <= ctl_next;
                line_reg     <= line_next;
                col_reg      <= col_next;
                tok_line_reg <= tok_line_next;
                tok_col_reg  <= tok_col_next;
            end
        end
    end

    jtl_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .ctl           (ctl_reg),
        .line_cnt      (line_reg),
        .col_cnt       (col_reg),
        .tok_line      (tok_line_reg),
        .tok_col       (tok_col_reg),
        .text_byte     (in_byte_reg),
        .end_of_text   (in_end_reg),
        .ctl_next      (ctl_next),
        .line_next     (line_next),
        .col_next      (col_next),
        .tok_line_next (tok_line_next),
        .tok_col_next  (tok_col_next),
        .events        (events)
    );

    jtl_evt_buf u_evt_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (proc),
        .events    (events),
        .free      (buf_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_event (out_event),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'b000000, out_event.err, out_event.column, out_event.line,
                      out_event.value};
    assign m_tuser = {out_event.code, out_event.kind};

endmodule

`default_nettype wire

// File: design/jtl_checker.sv
`default_nettype none

module jtl_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire [jtl_pkg::S_TDATA_W-1:0]   s_tdata,
    input wire                            s_tlast,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [jtl_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire [jtl_pkg::M_TUSER_W-1:0]   m_tuser,
    input wire                            m_tlast
);

    logic       s_fire;
    logic [2:0] ev_code;
    logic [3:0] tok_kind;

    assign s_fire   = s_tvalid && s_tready && (s_tdata[7:0] == s_tdata[7:0]) &&
                      (s_tlast == s_tlast);
    assign ev_code  = m_tuser[6:4];
    assign tok_kind = m_tuser[3:0];

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("word out right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("stalled word changed");

    a_err_only_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (ev_code != 3'(jtl_pkg::EV_ERROR)) |-> (m_tdata[41:40] == 2'b00))
        else $error("error code on non-error event");

    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (tok_kind == 4'(jtl_pkg::TOK_EOF)) |->
            m_tlast && (ev_code == 3'(jtl_pkg::EV_WHOLE)))
        else $error("eof not a closing whole token");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid || s_fire |-> (m_tdata[47:42] == 6'b000000) || !m_tvalid)
        else $error("tdata pad bits set");

endmodule

bind json_token_lexer_core jtl_checker u_jtl_checker (.*);

`default_nettype wire
